// ===== sv/nhsk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested HMAC-SHA1 key check package
// Shared types, constants and SHA-1 round functions.
// ----------------------------------------------------------------------------
package nhsk_pkg;

  // Sizes of the tail stores.
  localparam int MAX_SALT_BLOCKS  = 2;
  localparam int MAX_VALUE_BLOCKS = 16;
  localparam int SALT_DEPTH       = MAX_SALT_BLOCKS * 16;
  localparam int VAL_DEPTH        = MAX_VALUE_BLOCKS * 16;
  localparam int SALT_AW          = $clog2(SALT_DEPTH);
  localparam int VAL_AW           = $clog2(VAL_DEPTH);
  localparam int MAX_BLOCKS       = (MAX_VALUE_BLOCKS > MAX_SALT_BLOCKS) ?
                                    MAX_VALUE_BLOCKS : MAX_SALT_BLOCKS;
  localparam int BLK_W            = $clog2(((MAX_BLOCKS > 16) ? MAX_BLOCKS : 16) + 1);

  localparam logic [BLK_W-1:0] MAX_SALT_CNT = BLK_W'(MAX_SALT_BLOCKS);
  localparam logic [BLK_W-1:0] MAX_VAL_CNT  = BLK_W'(MAX_VALUE_BLOCKS);

  // HMAC constants.
  localparam logic [31:0] IPAD_WORD  = 32'h3636_3636;
  localparam logic [31:0] OPAD_WORD  = 32'h5C5C_5C5C;
  localparam logic [31:0] PAD_MARK   = 32'h8000_0000;
  localparam logic [31:0] OUTER_BITS = 32'h0000_02A0;

  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hEFCD_AB89;
  localparam logic [31:0] IV2 = 32'h98BA_DCFE;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

  localparam logic [6:0] LAST_ROUND = 7'd79;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [4:0][31:0]  dig_t;

  typedef enum logic [1:0] {
    OP_LOAD_SALT  = 2'd0,
    OP_LOAD_VALUE = 2'd1,
    OP_TEST       = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_DIG_HIGH  = 3'd0,
    CFG_DIG_MID   = 3'd1,
    CFG_DIG_LOW   = 3'd2,
    CFG_SALT_CNT  = 3'd3,
    CFG_VALUE_CNT = 3'd4
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IPAD,
    ST_IPAD_RUN,
    ST_FETCH,
    ST_TAIL,
    ST_TAIL_RUN,
    ST_OPAD,
    ST_OPAD_RUN,
    ST_OUTER,
    ST_OUTER_RUN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SEL_KEY_IPAD,
    SEL_TAIL,
    SEL_KEY_OPAD,
    SEL_INNER
  } blk_sel_e;

  // Control to the compression unit.
  typedef struct packed {
    logic start;
    logic init_iv;
  } sha_ctrl_t;

  // Status from the compression unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sha_stat_t;

  // Round constant.
  function automatic logic [31:0] sha_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = 32'h5A82_7999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9_EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  // Round logic function.
  function automatic logic [31:0] sha_f(input logic [6:0] t, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== sv/nhsk_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested HMAC-SHA1 key check channels
// Valid/ready interfaces for the request and result channels.
// ----------------------------------------------------------------------------
interface nhsk_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  word_index;
  logic [31:0] word_data;
  logic [6:0]  key_length;
  logic [63:0] key_bytes_0_7;
  logic [63:0] key_bytes_8_15;
  logic [63:0] key_bytes_16_23;
  logic [63:0] key_bytes_24_31;
  logic [63:0] key_bytes_32_39;
  logic [63:0] key_bytes_40_47;
  logic [63:0] key_bytes_48_55;
  logic [63:0] key_bytes_56_63;

  modport source(output valid, op, word_index, word_data, key_length, key_bytes_0_7,
                 key_bytes_8_15, key_bytes_16_23, key_bytes_24_31, key_bytes_32_39,
                 key_bytes_40_47, key_bytes_48_55, key_bytes_56_63, input ready);
  modport sink(input valid, op, word_index, word_data, key_length, key_bytes_0_7,
               key_bytes_8_15, key_bytes_16_23, key_bytes_24_31, key_bytes_32_39,
               key_bytes_40_47, key_bytes_48_55, key_bytes_56_63, output ready);
endinterface

interface nhsk_out_if;
  logic valid;
  logic ready;
  logic match;

  modport source(output valid, match, input ready);
  modport sink(input valid, match, output ready);
endinterface

// ===== sv/nhsk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nhsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/nhsk_sha1_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 compression unit
// One round per cycle over a sliding 16-word schedule, then the chaining add.
// ----------------------------------------------------------------------------
module nhsk_sha1_core import nhsk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sha_ctrl_t ctrl_i,
  input  blk_t      block_i,
  output sha_stat_t stat_o,
  output dig_t      digest_o
);

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  blk_t        w_q;
  dig_t        h_q;
  logic [6:0]  round_q;
  logic        busy_q, fin_q, done_q;
  logic [31:0] tmp, w_new;
  dig_t        start_h;

  // Round arithmetic and schedule expansion.
  assign tmp   = {a_q[26:0], a_q[31:27]} + sha_f(round_q, b_q, c_q, d_q) + e_q +
                 sha_k(round_q) + w_q[0];
  assign w_new = {(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]) << 1} |
                 {31'd0, w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
  assign start_h = ctrl_i.init_iv ? {IV4, IV3, IV2, IV1, IV0} : h_q;

  // Sequencing flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (ctrl_i.start && !busy_q) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        round_q <= round_q + 7'd1;
        if (round_q == LAST_ROUND) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Working variables, schedule and chaining value.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !busy_q) begin
      h_q <= start_h;
      a_q <= start_h[0];
      b_q <= start_h[1];
      c_q <= start_h[2];
      d_q <= start_h[3];
      e_q <= start_h[4];
      w_q <= block_i;
    end else if (busy_q) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      w_q <= {w_new, w_q[15:1]};
    end else if (fin_q) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

  assign stat_o.busy = busy_q | fin_q;
  assign stat_o.done = done_q;
  assign digest_o    = h_q;

`ifndef ASSERT_OFF
  a_fin_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && round_q == LAST_ROUND) |=> fin_q)
    else $error("chaining add did not follow the last round");
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> (done_q && !busy_q))
    else $error("done did not follow the chaining add");
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && fin_q))
    else $error("rounds and chaining add overlap");
`endif

endmodule

// ===== sv/nested_hmac_sha1_key_check.sv =====
`timescale 1ns / 1ps
// A test runs 6 + ns + nv SHA-1 compressions in the shared round unit, with ns and nv
// the salt and value block counts; each tail block is fetched from its store into the
// block register before its compression starts.
// At most one test is in flight; a load is taken in idle and the block stays idle. The next transaction is
// accepted once the test has handed its result to the output register.
// Reset is asynchronous: control and configuration clear at once, the tail stores do not.
// ----------------------------------------------------------------------------
// Nested HMAC-SHA1 key check
// Tests candidate keys against an expected digest of HMAC(HMAC(key, salt), value).
// ----------------------------------------------------------------------------
module nested_hmac_sha1_key_check import nhsk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nhsk_in_if.sink     in_i,
  nhsk_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  state_e            state_q, state_d;
  blk_sel_e          sel;
  sha_ctrl_t         ctrl;
  sha_stat_t         stat;
  dig_t              digest;
  blk_t              key_q, blk_q, core_blk, key_m;
  dig_t              inner_q;
  logic              phase_q;
  logic [4:0]        fetch_q;
  logic [BLK_W-1:0]  blk_idx_q, ns, nv, nblk;
  logic [BLK_W+3:0]  raddr;
  logic [63:0]       exp_hi_q, exp_mid_q;
  logic [31:0]       exp_lo_q, salt_rdata, val_rdata, tail_rdata;
  logic [1:0]        salt_cnt_q;
  logic [4:0]        val_cnt_q;
  logic              out_valid_q, out_match_q;
  logic              accept, salt_we, val_we, last_blk, out_free, eq;
  logic [511:0]      key_flat;

  // Acceptance and tail loads.
  assign accept  = in_i.valid && in_i.ready;
  assign salt_we = accept && (in_i.op == OP_LOAD_SALT) &&
                   ({1'b0, in_i.word_index} < 9'(SALT_DEPTH));
  assign val_we  = accept && (in_i.op == OP_LOAD_VALUE) &&
                   ({3'b0, in_i.word_index} < 11'(VAL_DEPTH));
  assign raddr   = {blk_idx_q, fetch_q[3:0]};

  nhsk_ram #(.WIDTH(32), .DEPTH(SALT_DEPTH)) u_salt_ram (
    .clk_i   (clk_i),
    .we_i    (salt_we),
    .waddr_i (SALT_AW'(in_i.word_index)),
    .wdata_i (in_i.word_data),
    .raddr_i (raddr[SALT_AW-1:0]),
    .rdata_o (salt_rdata)
  );

  nhsk_ram #(.WIDTH(32), .DEPTH(VAL_DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (VAL_AW'(in_i.word_index)),
    .wdata_i (in_i.word_data),
    .raddr_i (raddr[VAL_AW-1:0]),
    .rdata_o (val_rdata)
  );

  assign tail_rdata = phase_q ? val_rdata : salt_rdata;

  // Key masking: bytes at or beyond the key length read as zero.
  assign key_flat = {in_i.key_bytes_0_7, in_i.key_bytes_8_15, in_i.key_bytes_16_23,
                     in_i.key_bytes_24_31, in_i.key_bytes_32_39, in_i.key_bytes_40_47,
                     in_i.key_bytes_48_55, in_i.key_bytes_56_63};
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      key_m[b / 4][31 - 8 * (b % 4) -: 8] = (7'(b) < in_i.key_length) ?
                                             key_flat[511 - 8 * b -: 8] : 8'd0;
    end
  end

  // Block counts with out-of-range values pulled into range.
  always_comb begin
    ns = BLK_W'(salt_cnt_q);
    if (salt_cnt_q == 2'd0) begin
      ns = BLK_W'(1);
    end else if (ns > MAX_SALT_CNT) begin
      ns = MAX_SALT_CNT;
    end
    nv = BLK_W'(val_cnt_q);
    if (val_cnt_q == 5'd0) begin
      nv = BLK_W'(1);
    end else if (nv > MAX_VAL_CNT) begin
      nv = MAX_VAL_CNT;
    end
  end

  assign nblk     = phase_q ? nv : ns;
  assign last_blk = (blk_idx_q + BLK_W'(1)) == nblk;
  assign out_free = !out_valid_q || out_o.ready;
  assign eq       = (digest[0] == exp_hi_q[63:32]) && (digest[1] == exp_hi_q[31:0]) &&
                    (digest[2] == exp_mid_q[63:32]) && (digest[3] == exp_mid_q[31:0]) &&
                    (digest[4] == exp_lo_q);

  // Block presented to the compression unit.
  always_comb begin
    core_blk = blk_q;
    case (sel)
      SEL_KEY_IPAD: begin
        for (int i = 0; i < 16; i++) core_blk[i] = key_q[i] ^ IPAD_WORD;
      end
      SEL_KEY_OPAD: begin
        for (int i = 0; i < 16; i++) core_blk[i] = key_q[i] ^ OPAD_WORD;
      end
      SEL_INNER: begin
        core_blk = '0;
        for (int i = 0; i < 5; i++) core_blk[i] = inner_q[i];
        core_blk[5]  = PAD_MARK;
        core_blk[15] = OUTER_BITS;
      end
      default: core_blk = blk_q;
    endcase
  end

  nhsk_sha1_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .block_i  (core_blk),
    .stat_o   (stat),
    .digest_o (digest)
  );

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and unit control.
  always_comb begin
    state_d      = state_q;
    sel          = SEL_TAIL;
    ctrl         = '0;
    in_i.ready   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && in_i.op == OP_TEST) state_d = ST_IPAD;
      end
      ST_IPAD: begin
        ctrl.start   = 1'b1;
        ctrl.init_iv = 1'b1;
        sel          = SEL_KEY_IPAD;
        state_d      = ST_IPAD_RUN;
      end
      ST_IPAD_RUN: begin
        if (stat.done) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (fetch_q == 5'd16) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        ctrl.start = 1'b1;
        state_d    = ST_TAIL_RUN;
      end
      ST_TAIL_RUN: begin
        if (stat.done) state_d = last_blk ? ST_OPAD : ST_FETCH;
      end
      ST_OPAD: begin
        ctrl.start   = 1'b1;
        ctrl.init_iv = 1'b1;
        sel          = SEL_KEY_OPAD;
        state_d      = ST_OPAD_RUN;
      end
      ST_OPAD_RUN: begin
        if (stat.done) state_d = ST_OUTER;
      end
      ST_OUTER: begin
        ctrl.start = 1'b1;
        sel        = SEL_INNER;
        state_d    = ST_OUTER_RUN;
      end
      ST_OUTER_RUN: begin
        if (stat.done) state_d = phase_q ? ST_DONE : ST_IPAD;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control counters, result valid and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      fetch_q     <= '0;
      blk_idx_q   <= '0;
      out_valid_q <= 1'b0;
      exp_hi_q    <= '0;
      exp_mid_q   <= '0;
      exp_lo_q    <= '0;
      salt_cnt_q  <= 2'd1;
      val_cnt_q   <= 5'd1;
    end else begin
      if (accept && in_i.op == OP_TEST) phase_q <= 1'b0;
      if (state_q == ST_OUTER_RUN && stat.done && !phase_q) phase_q <= 1'b1;
      if (state_q == ST_FETCH) begin
        fetch_q <= (fetch_q == 5'd16) ? 5'd0 : fetch_q + 5'd1;
      end
      if (state_q == ST_TAIL_RUN && stat.done) begin
        blk_idx_q <= last_blk ? '0 : blk_idx_q + BLK_W'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIG_HIGH:  exp_hi_q   <= cfg_data_i;
          CFG_DIG_MID:   exp_mid_q  <= cfg_data_i;
          CFG_DIG_LOW:   exp_lo_q   <= cfg_data_i[31:0];
          CFG_SALT_CNT:  salt_cnt_q <= cfg_data_i[1:0];
          CFG_VALUE_CNT: val_cnt_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  // Key, tail block, inner digest and result payload.
  // The derived key is the first digest padded with zero words.
  always_ff @(posedge clk_i) begin
    if (accept && in_i.op == OP_TEST) begin
      key_q <= key_m;
    end else if (state_q == ST_OUTER_RUN && stat.done && !phase_q) begin
      key_q <= {352'd0, digest};
    end
    if (state_q == ST_FETCH && fetch_q != 5'd0) blk_q[4'(fetch_q - 5'd1)] <= tail_rdata;
    if (state_q == ST_OPAD) inner_q <= digest;
    if (state_q == ST_DONE && out_free) out_match_q <= eq;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.match = out_match_q;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == ST_IDLE))
    else $error("request taken outside idle");
  a_done_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> phase_q)
    else $error("result reached before the second HMAC");
  a_fetch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_q <= 5'd16)
    else $error("tail fetch counter overran");
  a_blk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (blk_idx_q < nblk))
    else $error("tail block index beyond block count");
  a_start_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |-> !stat.busy)
    else $error("compression started while the unit was busy");
`endif

endmodule
